// ----- rtl/gcr_pkg.sv -----
`timescale 1ns / 1ps
package gcr_pkg;

    localparam int DefaultPanelWidth  = 128;
    localparam int DefaultPanelHeight = 8;

    localparam int GlyphCols  = 5;
    localparam int GlyphRows  = 7;
    localparam int AsciiMax   = 127;
    localparam int FontDepth  = 640;
    localparam int GammaDepth = 256;

    // column and row of a pixel request, wide enough for a glyph that runs past 11 bits
    localparam int ColW = 13;
    localparam int RowW = 6;

    typedef enum logic [1:0] {
        KIND_LOAD_FONT  = 2'd0,
        KIND_LOAD_GAMMA = 2'd1,
        KIND_GLYPH      = 2'd2,
        KIND_PIXEL      = 2'd3
    } t_kind;

    localparam logic REG_MIRROR_H = 1'b0;
    localparam logic REG_MIRROR_V = 1'b1;

    typedef struct packed {
        logic                   valid;
        logic signed [ColW-1:0] col;
        logic signed [RowW-1:0] row;
        logic [7:0]             level;
        logic [10:0]            next_x;
        logic                   last;
    } t_pix_req;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_gamma_wr;

endpackage

// ----- rtl/glyph_column_renderer_top.sv -----
`timescale 1ns / 1ps
// Renders 5x7 font glyphs and single pixels into framebuffer write transactions for an LED
// panel. A transaction is taken when start is high and busy is low. Font and gamma loads
// complete in the accept cycle, return no result and leave busy low. A pixel transaction,
// or a glyph code above 127, gives one result and keeps busy high until it leaves the
// pixel unit. A glyph transaction reads its five font columns one per cycle, then sends
// one pixel request per cycle through the shared pixel unit (bounds check, mirror,
// address, gamma): seven rows for each drawn column (up to 5), then a spacer column of
// PANEL_HEIGHT rows unless the last drawn column is blank; a blank glyph gives one
// unwritten result. Results come one per cycle on o_strobe and cannot be held off;
// every result of a transaction carries the same o_next_x, and o_last marks the final one.
// Mirror settings must be written only while idle; the block itself does not enforce it.
module glyph_column_renderer_top #(
    parameter int PANEL_WIDTH  = gcr_pkg::DefaultPanelWidth,
    parameter int PANEL_HEIGHT = gcr_pkg::DefaultPanelHeight
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  logic signed [10:0] i_x_pos,
    input  logic signed [4:0] i_y_pos,
    input  logic [9:0]        i_table_index,
    input  logic [7:0]        i_data_value,
    input  logic [7:0]        i_fore_colour,
    input  logic [7:0]        i_back_colour,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data,
    output logic              o_strobe,
    output logic              o_written,
    output logic [9:0]        o_pixel_address,
    output logic [7:0]        o_pixel_value,
    output logic signed [10:0] o_next_x,
    output logic              o_last
);

    localparam int RW = $clog2(PANEL_HEIGHT);
    localparam int CW = gcr_pkg::ColW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_EMIT,
        S_ONE,
        S_DRAIN
    } t_state;

    t_state r_state;

    logic              r_mirror_h;
    logic              r_mirror_v;
    logic signed [CW-1:0] r_x;
    logic signed [gcr_pkg::RowW-1:0] r_y;
    logic [7:0]        r_level;
    logic [7:0]        r_fg;
    logic [7:0]        r_bg;
    logic [10:0]       r_next_x;
    logic [9:0]        r_base;
    logic [2:0]        r_cnt;
    logic [7:0]        r_prev;
    logic [7:0]        r_cols [gcr_pkg::GlyphCols];
    logic [2:0]        r_ncols;
    logic              r_spacer;
    logic [2:0]        r_ecol;
    logic [RW-1:0]     r_row;

    logic              accept;
    gcr_pkg::t_kind    kind;
    logic              font_we;
    logic [9:0]        font_raddr;
    logic [7:0]        font_q;
    gcr_pkg::t_gamma_wr gwr;
    gcr_pkg::t_pix_req req;

    logic              is_spacer;
    logic [7:0]        col_byte;
    logic              col_end;
    logic              emit_last;
    logic              col_keep;
    logic [9:0]        n_base;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign kind   = gcr_pkg::t_kind'(i_kind);

    assign font_we    = accept && (kind == gcr_pkg::KIND_LOAD_FONT)
                     && (i_table_index < 10'(gcr_pkg::FontDepth));
    assign font_raddr = r_base + 10'(r_cnt);
    assign n_base     = {1'b0, i_data_value[6:0], 2'b00} + {3'b000, i_data_value[6:0]};

    always_comb begin
        gwr.we   = accept && (kind == gcr_pkg::KIND_LOAD_GAMMA) && (i_table_index[9:8] == 2'b00);
        gwr.addr = i_table_index[7:0];
        gwr.data = i_data_value;
    end

    // skip a blank column unless the column before it was drawn
    assign col_keep = (r_prev != 8'd0) || (font_q != 8'd0);

    always_comb begin
        is_spacer = r_spacer && (r_ecol == r_ncols);
        col_byte  = r_cols[r_ecol];
        col_end   = is_spacer ? (r_row == RW'(PANEL_HEIGHT - 1))
                              : (r_row == RW'(gcr_pkg::GlyphRows - 1));
        emit_last = col_end && (is_spacer || (!r_spacer && (r_ecol == r_ncols - 3'd1)));

        req.valid  = 1'b0;
        req.col    = r_x;
        req.row    = r_y;
        req.level  = r_level;
        req.next_x = r_next_x;
        req.last   = 1'b1;
        unique case (r_state)
            S_EMIT: begin
                req.valid = 1'b1;
                req.col   = r_x + CW'(r_ecol);
                req.row   = gcr_pkg::RowW'(r_row);
                req.level = (!is_spacer && col_byte[r_row[2:0]]) ? r_fg : r_bg;
                req.last  = emit_last;
            end
            S_ONE: begin
                req.valid = 1'b1;
            end
            default: begin
                req.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mirror_h <= 1'b0;
            r_mirror_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gcr_pkg::REG_MIRROR_H: r_mirror_h <= i_cfg_data;
                    gcr_pkg::REG_MIRROR_V: r_mirror_v <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_next_x <= i_x_pos;
                        r_fg     <= i_fore_colour;
                        r_bg     <= i_back_colour;
                        r_cnt    <= 3'd0;
                        r_prev   <= 8'd0;
                        r_ncols  <= 3'd0;
                        r_base   <= n_base;
                        if (kind == gcr_pkg::KIND_PIXEL) begin
                            r_x     <= CW'(i_x_pos);
                            r_y     <= gcr_pkg::RowW'(i_y_pos);
                            r_level <= i_data_value;
                            r_state <= S_ONE;
                        end else if (kind == gcr_pkg::KIND_GLYPH) begin
                            if (i_data_value > 8'(gcr_pkg::AsciiMax)) begin
                                r_x     <= '1;
                                r_y     <= '1;
                                r_level <= 8'd0;
                                r_state <= S_ONE;
                            end else begin
                                r_x     <= CW'(i_x_pos);
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cnt != 3'd0 && col_keep) begin
                        r_cols[r_ncols] <= font_q;
                        r_ncols         <= r_ncols + 3'd1;
                        r_prev          <= font_q;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'(gcr_pkg::GlyphCols)) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_spacer <= (r_prev != 8'd0);
                    r_ecol   <= 3'd0;
                    r_row    <= '0;
                    if (r_ncols == 3'd0) begin
                        r_x     <= '1;
                        r_y     <= '1;
                        r_level <= 8'd0;
                        r_state <= S_ONE;
                    end else begin
                        r_next_x <= 11'(r_x + CW'(r_ncols) + CW'(r_prev != 8'd0));
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (col_end) begin
                        r_row  <= '0;
                        r_ecol <= r_ecol + 3'd1;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                    if (emit_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_ONE: begin
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    // hold until the final result leaves the pixel unit
                    if (o_strobe && o_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    gcr_font_store u_font (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (i_table_index),
        .i_wdata (i_data_value),
        .i_raddr (font_raddr),
        .o_rdata (font_q)
    );

    gcr_pixel_unit #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_pix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mirror_h      (r_mirror_h),
        .i_mirror_v      (r_mirror_v),
        .i_req           (req),
        .i_gwr           (gwr),
        .o_strobe        (o_strobe),
        .o_written       (o_written),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_next_x        (o_next_x),
        .o_last          (o_last)
    );

endmodule

// ----- rtl/gcr_font_store.sv -----
`timescale 1ns / 1ps
module gcr_font_store (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [9:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic [9:0] i_raddr,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [gcr_pkg::FontDepth];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gcr_pixel_unit.sv -----
`timescale 1ns / 1ps
module gcr_pixel_unit #(
    parameter int PANEL_WIDTH  = gcr_pkg::DefaultPanelWidth,
    parameter int PANEL_HEIGHT = gcr_pkg::DefaultPanelHeight
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mirror_h,
    input  logic                i_mirror_v,
    input  gcr_pkg::t_pix_req   i_req,
    input  gcr_pkg::t_gamma_wr  i_gwr,
    output logic                o_strobe,
    output logic                o_written,
    output logic [9:0]          o_pixel_address,
    output logic [7:0]          o_pixel_value,
    output logic [10:0]         o_next_x,
    output logic                o_last
);

    localparam int CW = $clog2(PANEL_WIDTH);
    localparam int RW = $clog2(PANEL_HEIGHT);
    localparam int AW = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
    localparam int LW = (AW > 10) ? AW : 10;

    // stage A: request
    gcr_pkg::t_pix_req r_a;

    // stage B: address and gamma lookup
    logic        r_b_valid;
    logic        r_b_written;
    logic [9:0]  r_b_addr;
    logic [7:0]  r_b_level;
    logic [7:0]  r_b_gq;
    logic        r_b_gv;
    logic [10:0] r_b_next_x;
    logic        r_b_last;

    // stage C: outputs
    logic        r_c_valid;
    logic        r_c_written;
    logic [9:0]  r_c_addr;
    logic [7:0]  r_c_value;
    logic [10:0] r_c_next_x;
    logic        r_c_last;

    logic [7:0] r_gmem [gcr_pkg::GammaDepth];
    logic [gcr_pkg::GammaDepth-1:0] r_gvalid;

    logic          in_panel;
    logic [CW-1:0] col_u;
    logic [RW-1:0] row_u;
    logic [CW-1:0] col_m;
    logic [RW-1:0] row_m;
    logic [LW-1:0] lin;

    always_comb begin
        in_panel = (r_a.col >= $signed(gcr_pkg::ColW'(0)))
                && (r_a.col <  $signed(gcr_pkg::ColW'(PANEL_WIDTH)))
                && (r_a.row >= $signed(gcr_pkg::RowW'(0)))
                && (r_a.row <  $signed(gcr_pkg::RowW'(PANEL_HEIGHT)));
        col_u = r_a.col[CW-1:0];
        row_u = r_a.row[RW-1:0];
        col_m = i_mirror_h ? CW'(PANEL_WIDTH - 1) - col_u : col_u;
        row_m = i_mirror_v ? RW'(PANEL_HEIGHT - 1) - row_u : row_u;
        lin   = LW'(row_m) * LW'(PANEL_WIDTH) + LW'(col_m);
    end

    always_ff @(posedge i_clk) begin
        if (i_gwr.we) begin
            r_gmem[i_gwr.addr] <= i_gwr.data;
        end
        r_b_gq <= r_gmem[r_a.level];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvalid  <= '0;
            r_a       <= '0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (i_gwr.we) begin
                r_gvalid[i_gwr.addr] <= 1'b1;
            end
            r_a       <= i_req;
            r_b_valid <= r_a.valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_written <= in_panel;
        r_b_addr    <= in_panel ? lin[9:0] : 10'd0;
        r_b_level   <= r_a.level;
        r_b_gv      <= r_gvalid[r_a.level];
        r_b_next_x  <= r_a.next_x;
        r_b_last    <= r_a.last;

        r_c_written <= r_b_written;
        r_c_addr    <= r_b_addr;
        // an entry never loaded passes the level through unchanged, as its identity value
        r_c_value   <= !r_b_written ? 8'd0 : (r_b_gv ? r_b_gq : r_b_level);
        r_c_next_x  <= r_b_next_x;
        r_c_last    <= r_b_last;
    end

    assign o_strobe        = r_c_valid;
    assign o_written       = r_c_written;
    assign o_pixel_address = r_c_addr;
    assign o_pixel_value   = r_c_value;
    assign o_next_x        = r_c_next_x;
    assign o_last          = r_c_last;

endmodule
